@@ design/nes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nes_pkg
// shared types and codes for the note event scheduler
// ----------------------------------------------------------------------------
package nes_pkg;

  localparam int unsigned DefMaxEvents  = 16;
  localparam int unsigned DefMaxHeld    = 16;
  localparam int unsigned DefTimeBits   = 24;
  localparam int unsigned DefPayloadBits = 32;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_ACK  = 2'd3
  } kind_t;

endpackage
`default_nettype wire

@@ design/note_event_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// note_event_scheduler
// timed note-on / note-off scheduler for one track
// ----------------------------------------------------------------------------
// a command beat is taken when start is high and busy low; it lands in a
// two-entry queue and the engine works it off one at a time, no earlier
// than the cycle after it was taken. results leave as single-cycle strobes
// and cannot be held off. begin records the cycle length and acks; add
// walks the pending list one slot a cycle to insert (a full list only acks
// with overflow); stop fires an off per held note, then acks; a tick fires
// due ons, bubble-sorts held notes (one compare a cycle, one pass per held
// note at worst), fires and compacts offs, sends the done beat and copies
// the bank at cycle end. the single sequencer walking the stores sets all time.
module note_event_scheduler import nes_pkg::*; #(
  parameter int unsigned MAX_EVENTS   = DefMaxEvents,
  parameter int unsigned MAX_HELD     = DefMaxHeld,
  parameter int unsigned TIME_BITS    = DefTimeBits,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              action,
  input  wire logic [TIME_BITS-1:0]    cycle_ticks,
  input  wire logic [TIME_BITS-1:0]    event_start,
  input  wire logic [TIME_BITS-1:0]    event_ticks,
  input  wire logic [PAYLOAD_BITS-1:0] event_value,
  output logic                         strobe,
  output logic [1:0]                   kind,
  output logic [PAYLOAD_BITS-1:0]      value,
  output logic                         cycle_ended,
  output logic                         overflow,
  output logic                         last
);
  localparam int unsigned QW = 2 + 2 * TIME_BITS + PAYLOAD_BITS;

  logic [QW-1:0]           q_in;
  logic [QW-1:0]           q_out;
  logic                    q_full;
  logic                    q_nempty;
  logic                    pop;
  logic                    eng_idle;
  logic [TIME_BITS-1:0]    a_field;
  kind_t                   kind_r;

  // front end: begin carries cycle length in field a, add its start
  assign a_field = (action == 2'(ACT_BEGIN)) ? cycle_ticks : event_start;
  assign q_in    = {action, a_field, event_ticks, event_value};
  assign busy    = q_full;

  nes_cmd_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst),
    .push(start && !busy), .push_data(q_in), .full(q_full),
    .pop(pop), .pop_data(q_out), .not_empty(q_nempty)
  );

  nes_engine #(
    .MAX_EVENTS(MAX_EVENTS), .MAX_HELD(MAX_HELD),
    .TIME_BITS(TIME_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(q_nempty),
    .cmd_action(action_t'(q_out[QW-1 -: 2])),
    .cmd_a(q_out[QW-3 -: TIME_BITS]),
    .cmd_b(q_out[PAYLOAD_BITS +: TIME_BITS]),
    .cmd_value(q_out[PAYLOAD_BITS-1:0]),
    .cmd_pop(pop), .idle(eng_idle),
    .res_strobe(strobe), .res_kind(kind_r), .res_value(value),
    .res_cycle_ended(cycle_ended), .res_overflow(overflow), .res_last(last)
  );

  assign kind = kind_r;

`ifndef SYNTHESIS
  // the engine only pops when it is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> eng_idle)
    else $error("pop while engine busy");
  // a cycle end is only flagged on a tick-done beat
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    (strobe && cycle_ended) |-> (kind_r == KIND_TICK))
    else $error("cycle end on wrong beat");
  // overflow only on the final beat
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && overflow) |-> last)
    else $error("overflow not on last beat");
`endif
endmodule
`default_nettype wire

@@ design/nes_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nes_cmd_queue
// short command queue between the front end and the engine
// ----------------------------------------------------------------------------
module nes_cmd_queue import nes_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full      = (fill == (AW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end
endmodule
`default_nettype wire

@@ design/nes_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nes_engine
// sequencer that carries out begin, add, tick and stop on the event stores
// ----------------------------------------------------------------------------
module nes_engine import nes_pkg::*; #(
  parameter int unsigned MAX_EVENTS   = DefMaxEvents,
  parameter int unsigned MAX_HELD     = DefMaxHeld,
  parameter int unsigned TIME_BITS    = DefTimeBits,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  input  wire action_t                 cmd_action,
  input  wire logic [TIME_BITS-1:0]    cmd_a,
  input  wire logic [TIME_BITS-1:0]    cmd_b,
  input  wire logic [PAYLOAD_BITS-1:0] cmd_value,
  output logic                         cmd_pop,
  output logic                         idle,
  output logic                         res_strobe,
  output kind_t                        res_kind,
  output logic [PAYLOAD_BITS-1:0]      res_value,
  output logic                         res_cycle_ended,
  output logic                         res_overflow,
  output logic                         res_last
);
  localparam int unsigned EW = $clog2(MAX_EVENTS);
  localparam int unsigned HW = $clog2(MAX_HELD);
  localparam int unsigned EC = EW + 1;
  localparam int unsigned HC = HW + 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SHIFT  = 10'b0000000010,
    S_ON     = 10'b0000000100,
    S_SORT   = 10'b0000001000,
    S_OFF    = 10'b0000010000,
    S_DONE   = 10'b0000100000,
    S_COPY   = 10'b0001000000,
    S_STOP   = 10'b0010000000,
    S_ACK    = 10'b0100000000,
    S_SORTIN = 10'b1000000000
  } state_t;

  state_t state;

  // two banks of event stores, active and pending; pending is copied to active at cycle end
  logic [TIME_BITS-1:0]    act_start [MAX_EVENTS];
  logic [TIME_BITS-1:0]    act_len   [MAX_EVENTS];
  logic [PAYLOAD_BITS-1:0] act_pay   [MAX_EVENTS];
  logic [TIME_BITS-1:0]    pen_start [MAX_EVENTS];
  logic [TIME_BITS-1:0]    pen_len   [MAX_EVENTS];
  logic [PAYLOAD_BITS-1:0] pen_pay   [MAX_EVENTS];
  logic [TIME_BITS-1:0]    held_rem  [MAX_HELD];
  logic [PAYLOAD_BITS-1:0] held_pay  [MAX_HELD];

  logic [EC-1:0]        act_count;
  logic [EC-1:0]        pen_count;
  logic [HC-1:0]        held_count;
  logic [EC-1:0]        on_idx;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] act_cycle;
  logic [TIME_BITS-1:0] pen_cycle;

  logic [EC-1:0]        ptr;
  logic [HC-1:0]        hptr;
  logic [HC-1:0]        wr;
  logic                 ovf;
  logic [TIME_BITS-1:0] add_start;
  logic [TIME_BITS-1:0] add_len;
  logic [PAYLOAD_BITS-1:0] add_pay;
  logic                 sort_done;
  logic [TIME_BITS-1:0] elapsed_inc;

  assign idle        = (state == S_IDLE);
  assign cmd_pop     = idle && cmd_valid;
  assign elapsed_inc = elapsed + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      act_count  <= '0;
      pen_count  <= '0;
      held_count <= '0;
      on_idx     <= '0;
      elapsed    <= '0;
      act_cycle  <= '0;
      pen_cycle  <= '0;
      res_strobe <= 1'b0;
      ptr        <= '0;
      hptr       <= '0;
      wr         <= '0;
      ovf        <= 1'b0;
      sort_done  <= 1'b0;
    end else begin
      res_strobe      <= 1'b0;
      res_cycle_ended <= 1'b0;
      res_overflow    <= 1'b0;
      res_last        <= 1'b0;
      res_value       <= '0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            ovf <= 1'b0;
            unique case (cmd_action)
              ACT_BEGIN: begin
                pen_cycle <= cmd_a;
                pen_count <= '0;
                state     <= S_ACK;
              end
              ACT_ADD: begin
                add_start <= cmd_a;
                add_len   <= cmd_b;
                add_pay   <= cmd_value;
                ptr       <= pen_count;
                if (pen_count == EC'(MAX_EVENTS)) begin
                  ovf   <= 1'b1;
                  state <= S_ACK;
                end else begin
                  state <= S_SHIFT;
                end
              end
              ACT_TICK: state <= S_ON;
              ACT_STOP: begin
                hptr  <= '0;
                state <= S_STOP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // insertion walks down one slot a cycle
        S_SHIFT: begin
          if (ptr != '0 && pen_start[ptr[EW-1:0] - 1'b1] > add_start) begin
            pen_start[ptr[EW-1:0]] <= pen_start[ptr[EW-1:0] - 1'b1];
            pen_len[ptr[EW-1:0]]   <= pen_len[ptr[EW-1:0] - 1'b1];
            pen_pay[ptr[EW-1:0]]   <= pen_pay[ptr[EW-1:0] - 1'b1];
            ptr <= ptr - 1'b1;
          end else begin
            pen_start[ptr[EW-1:0]] <= add_start;
            pen_len[ptr[EW-1:0]]   <= add_len;
            pen_pay[ptr[EW-1:0]]   <= add_pay;
            pen_count <= pen_count + 1'b1;
            state     <= S_ACK;
          end
        end
        S_ON: begin
          if (on_idx < act_count && act_start[on_idx[EW-1:0]] <= elapsed) begin
            res_strobe <= 1'b1;
            res_kind   <= KIND_ON;
            res_value  <= act_pay[on_idx[EW-1:0]];
            if (act_len[on_idx[EW-1:0]] != '0) begin
              if (held_count != HC'(MAX_HELD)) begin
                held_rem[held_count[HW-1:0]] <= act_len[on_idx[EW-1:0]];
                held_pay[held_count[HW-1:0]] <= act_pay[on_idx[EW-1:0]];
                held_count <= held_count + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
            end
            on_idx <= on_idx + 1'b1;
          end else begin
            hptr      <= HC'(1);
            sort_done <= 1'b1;
            state     <= S_SORT;
          end
        end
        // bubble sort, one adjacent compare a cycle, stable
        S_SORT: begin
          if (hptr >= held_count) begin
            if (sort_done) begin
              hptr  <= '0;
              wr    <= '0;
              state <= S_OFF;
            end else begin
              hptr      <= HC'(1);
              sort_done <= 1'b1;
            end
          end else begin
            if (held_rem[hptr[HW-1:0] - 1'b1] > held_rem[hptr[HW-1:0]]) begin
              held_rem[hptr[HW-1:0]]        <= held_rem[hptr[HW-1:0] - 1'b1];
              held_pay[hptr[HW-1:0]]        <= held_pay[hptr[HW-1:0] - 1'b1];
              held_rem[hptr[HW-1:0] - 1'b1] <= held_rem[hptr[HW-1:0]];
              held_pay[hptr[HW-1:0] - 1'b1] <= held_pay[hptr[HW-1:0]];
              sort_done <= 1'b0;
            end
            hptr <= hptr + 1'b1;
          end
        end
        // fire zeros, decrement and compact the rest
        S_OFF: begin
          if (hptr < held_count) begin
            if (held_rem[hptr[HW-1:0]] == '0) begin
              res_strobe <= 1'b1;
              res_kind   <= KIND_OFF;
              res_value  <= held_pay[hptr[HW-1:0]];
            end else begin
              held_rem[wr[HW-1:0]] <= held_rem[hptr[HW-1:0]] - 1'b1;
              held_pay[wr[HW-1:0]] <= held_pay[hptr[HW-1:0]];
              wr <= wr + 1'b1;
            end
            hptr <= hptr + 1'b1;
          end else begin
            held_count <= wr;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          res_strobe <= 1'b1;
          res_kind   <= KIND_TICK;
          res_last   <= 1'b1;
          res_overflow <= ovf;
          if (elapsed_inc >= act_cycle) begin
            res_cycle_ended <= 1'b1;
            held_count <= '0;
            elapsed    <= '0;
            on_idx     <= '0;
            act_count  <= pen_count;
            act_cycle  <= pen_cycle;
            ptr        <= '0;
            state      <= S_COPY;
          end else begin
            elapsed <= elapsed_inc;
            state   <= S_IDLE;
          end
        end
        S_COPY: begin
          act_start[ptr[EW-1:0]] <= pen_start[ptr[EW-1:0]];
          act_len[ptr[EW-1:0]]   <= pen_len[ptr[EW-1:0]];
          act_pay[ptr[EW-1:0]]   <= pen_pay[ptr[EW-1:0]];
          if (ptr == EC'(MAX_EVENTS - 1)) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_STOP: begin
          if (hptr < held_count) begin
            res_strobe <= 1'b1;
            res_kind   <= KIND_OFF;
            res_value  <= held_pay[hptr[HW-1:0]];
            hptr <= hptr + 1'b1;
          end else begin
            held_count <= '0;
            state      <= S_ACK;
          end
        end
        S_ACK: begin
          res_strobe   <= 1'b1;
          res_kind     <= KIND_ACK;
          res_last     <= 1'b1;
          res_overflow <= ovf;
          state        <= S_IDLE;
        end
        S_SORTIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
